### rtl/lz77_token_decompressor_defines.svh
// Assertion macros shared by the decompressor RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef LZ77_TOKEN_DECOMPRESSOR_DEFINES_SVH
`define LZ77_TOKEN_DECOMPRESSOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LZD_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked outside reset.
`define LZD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### rtl/lzd_pkg.sv
// Shared constants and types for the LZ77 token decompressor.
// No dependencies; imported by lzd_window and the top level.
package lzd_pkg;

    localparam int LZD_WINDOW_BITS = 12;
    localparam int LZD_OUT_LANES   = 8;
    localparam int LZD_CNT_W       = 4;
    localparam int LZD_LEN_W       = 9;
    localparam int LZD_MIN_COPY    = 3;
    localparam int LZD_OFF_W       = 15;
    localparam int LZD_TDATA_W     = 72;

    localparam logic [7:0] LZD_MAGIC0 = 8'h4D;
    localparam logic [7:0] LZD_MAGIC1 = 8'h5A;

    typedef enum logic [1:0] {
        ST_DATA     = 2'd0,
        ST_FINISHED = 2'd1,
        ST_BADMAGIC = 2'd2,
        ST_TRUNC    = 2'd3
    } t_status;

endpackage

### rtl/lz77_token_decompressor.sv
// LZ77 token decompressor: one compressed byte per input transfer (tlast ends the
// stream and rearms the block), decoded bytes packed up to eight per output transfer.
// Each byte passes the decode, check and end states; a copy adds a read and a write
// state per copied byte and a flush state per full pack of eight that more copied
// bytes follow, set by the single window read port whose data is registered. Output
// waits stall the flush and end states. The window needs no clearing pass: entries
// not yet written since reset or rearm read as zero through a fill mark.
// Depends on lzd_pkg, lzd_window, defines.
`include "lz77_token_decompressor_defines.svh"

module lz77_token_decompressor
    import lzd_pkg::*;
#(
    parameter int WINDOW_BITS = LZD_WINDOW_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [7:0]             i_s_tdata,   // [7:0] in_byte
    input  logic                   i_s_tlast,   // end_of_stream
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [LZD_TDATA_W-1:0] o_m_tdata,   // [63:0] out_bytes, [67:64] byte_count
    output logic                   o_m_tlast,   // last_in_run
    output logic [1:0]             o_m_tuser    // [1:0] status
);

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_RD, S_WR, S_FLUSH, S_CHECK, S_END
    } t_state;

    typedef enum logic [3:0] {
        PH_MAGIC0 = 4'd0,
        PH_MAGIC1 = 4'd1,
        PH_SIZE0  = 4'd2,
        PH_SIZE1  = 4'd3,
        PH_SIZE2  = 4'd4,
        PH_SIZE3  = 4'd5,
        PH_TOKEN  = 4'd6,
        PH_OFFLO  = 4'd7,
        PH_LEN    = 4'd8,
        PH_DONE   = 4'd9,
        PH_ERROR  = 4'd10
    } t_phase;

    localparam int PACK_W = 8 * LZD_OUT_LANES;

    t_state                  r_state, n_state;
    t_phase                  r_phase, n_phase;
    logic [7:0]              r_byte, n_byte;
    logic                    r_eos, n_eos;
    logic [31:0]             r_size, n_size;
    logic [31:0]             r_prod, n_prod;
    logic [LZD_OFF_W-1:0]    r_off, n_off;
    logic [WINDOW_BITS-1:0]  r_wp, n_wp;
    logic                    r_wrapped, n_wrapped;
    logic [LZD_LEN_W-1:0]    r_len, n_len;
    logic                    r_rd_ok, n_rd_ok;
    logic [PACK_W-1:0]       r_pack, n_pack;
    logic [LZD_CNT_W-1:0]    r_cnt, n_cnt;
    logic                    r_has_final, n_has_final;
    t_status                 r_final, n_final;
    logic                    r_ov, n_ov;
    logic [PACK_W-1:0]       r_o_bytes, n_o_bytes;
    logic [LZD_CNT_W-1:0]    r_o_cnt, n_o_cnt;
    logic                    r_o_last, n_o_last;
    t_status                 r_o_status, n_o_status;

    logic                    ram_we;
    logic [7:0]              ram_wdata;
    logic                    ram_re;
    logic [WINDOW_BITS-1:0]  ram_raddr;
    logic [7:0]              ram_rdata;
    logic                    put;
    logic [7:0]              put_byte;
    logic                    out_free;
    logic                    prod_lt_size;

    lzd_window #(
        .ADDR_BITS (WINDOW_BITS)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign ram_raddr    = r_wp - r_off[WINDOW_BITS-1:0];
    assign out_free     = !r_ov || i_m_tready;
    assign prod_lt_size = r_prod < r_size;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_byte      = r_byte;
        n_eos       = r_eos;
        n_size      = r_size;
        n_prod      = r_prod;
        n_off       = r_off;
        n_wp        = r_wp;
        n_wrapped   = r_wrapped;
        n_len       = r_len;
        n_rd_ok     = r_rd_ok;
        n_pack      = r_pack;
        n_cnt       = r_cnt;
        n_has_final = r_has_final;
        n_final     = r_final;
        n_ov        = r_ov;
        n_o_bytes   = r_o_bytes;
        n_o_cnt     = r_o_cnt;
        n_o_last    = r_o_last;
        n_o_status  = r_o_status;
        ram_re      = 1'b0;
        put         = 1'b0;
        put_byte    = r_byte;

        if (r_ov && i_m_tready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_byte  = i_s_tdata;
                    n_eos   = i_s_tlast;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_CHECK;
                case (r_phase)
                    PH_MAGIC0, PH_MAGIC1: begin
                        if (r_byte == ((r_phase == PH_MAGIC0) ? LZD_MAGIC0 : LZD_MAGIC1)) begin
                            n_phase = (r_phase == PH_MAGIC0) ? PH_MAGIC1 : PH_SIZE0;
                        end else begin
                            n_has_final = 1'b1;
                            n_final     = ST_BADMAGIC;
                            n_phase     = PH_ERROR;
                        end
                    end
                    PH_SIZE0: begin
                        n_size[7:0] = r_byte;
                        n_phase     = PH_SIZE1;
                    end
                    PH_SIZE1: begin
                        n_size[15:8] = r_byte;
                        n_phase      = PH_SIZE2;
                    end
                    PH_SIZE2: begin
                        n_size[23:16] = r_byte;
                        n_phase       = PH_SIZE3;
                    end
                    PH_SIZE3: begin
                        n_size[31:24] = r_byte;
                        n_phase       = PH_TOKEN;
                    end
                    PH_TOKEN: begin
                        if (r_byte[7]) begin
                            n_off   = {8'd0, r_byte[6:0]};
                            n_phase = PH_OFFLO;
                        end else begin
                            put = 1'b1;
                        end
                    end
                    PH_OFFLO: begin
                        n_off   = {r_off[6:0], r_byte};
                        n_phase = PH_LEN;
                    end
                    PH_LEN: begin
                        if (r_off == '0) begin
                            n_has_final = 1'b1;
                            n_final     = ST_FINISHED;
                            n_phase     = PH_DONE;
                        end else begin
                            n_len   = LZD_LEN_W'(r_byte) + LZD_LEN_W'(LZD_MIN_COPY);
                            n_phase = PH_TOKEN;
                            n_state = S_RD;
                        end
                    end
                    default: ;
                endcase
            end
            S_RD: begin
                if (r_len == '0 || !prod_lt_size) begin
                    n_state = S_CHECK;
                end else if (r_cnt == LZD_CNT_W'(LZD_OUT_LANES)) begin
                    n_state = S_FLUSH;
                end else begin
                    ram_re  = 1'b1;
                    n_rd_ok = r_wrapped || (ram_raddr < r_wp);
                    n_state = S_WR;
                end
            end
            S_WR: begin
                put      = 1'b1;
                put_byte = r_rd_ok ? ram_rdata : 8'd0;
                n_len    = r_len - LZD_LEN_W'(1);
                n_state  = S_RD;
            end
            S_FLUSH: begin
                if (out_free) begin
                    n_ov       = 1'b1;
                    n_o_bytes  = r_pack;
                    n_o_cnt    = r_cnt;
                    n_o_last   = 1'b0;
                    n_o_status = ST_DATA;
                    n_pack     = '0;
                    n_cnt      = '0;
                    n_state    = S_RD;
                end
            end
            S_CHECK: begin
                n_state = S_END;
                if (r_phase == PH_TOKEN && !prod_lt_size) begin
                    n_has_final = 1'b1;
                    n_final     = ST_FINISHED;
                    n_phase     = PH_DONE;
                end else if (r_eos && !r_has_final) begin
                    if (r_phase == PH_TOKEN) begin
                        n_has_final = 1'b1;
                        n_final     = ST_FINISHED;
                    end else if (r_phase < PH_DONE) begin
                        n_has_final = 1'b1;
                        n_final     = ST_TRUNC;
                    end
                end
            end
            S_END: begin
                if ((r_cnt == '0 && !r_has_final) || out_free) begin
                    if (r_cnt != '0 || r_has_final) begin
                        n_ov       = 1'b1;
                        n_o_bytes  = r_pack;
                        n_o_cnt    = r_cnt;
                        n_o_last   = 1'b1;
                        n_o_status = r_has_final ? r_final : ST_DATA;
                    end
                    n_pack      = '0;
                    n_cnt       = '0;
                    n_has_final = 1'b0;
                    n_state     = S_IDLE;
                    if (r_eos) begin
                        n_phase   = PH_MAGIC0;
                        n_size    = '0;
                        n_prod    = '0;
                        n_off     = '0;
                        n_wp      = '0;
                        n_wrapped = 1'b0;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        ram_we    = put;
        ram_wdata = put_byte;
        if (put) begin
            n_pack[8*r_cnt[2:0] +: 8] = put_byte;
            n_cnt  = r_cnt + LZD_CNT_W'(1);
            n_prod = r_prod + 32'd1;
            n_wp   = r_wp + WINDOW_BITS'(1);
            if (&r_wp) begin
                n_wrapped = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_MAGIC0;
            r_eos       <= 1'b0;
            r_size      <= '0;
            r_prod      <= '0;
            r_off       <= '0;
            r_wp        <= '0;
            r_wrapped   <= 1'b0;
            r_len       <= '0;
            r_rd_ok     <= 1'b0;
            r_pack      <= '0;
            r_cnt       <= '0;
            r_has_final <= 1'b0;
            r_final     <= ST_DATA;
            r_ov        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_eos       <= n_eos;
            r_size      <= n_size;
            r_prod      <= n_prod;
            r_off       <= n_off;
            r_wp        <= n_wp;
            r_wrapped   <= n_wrapped;
            r_len       <= n_len;
            r_rd_ok     <= n_rd_ok;
            r_pack      <= n_pack;
            r_cnt       <= n_cnt;
            r_has_final <= n_has_final;
            r_final     <= n_final;
            r_ov        <= n_ov;
        end
        r_byte     <= n_byte;
        r_o_bytes  <= n_o_bytes;
        r_o_cnt    <= n_o_cnt;
        r_o_last   <= n_o_last;
        r_o_status <= n_o_status;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {{(LZD_TDATA_W - PACK_W - LZD_CNT_W){1'b0}}, r_o_cnt, r_o_bytes};
    assign o_m_tlast  = r_o_last;
    assign o_m_tuser  = r_o_status;

    `LZD_ASSERT_NEXT(a_accept_decodes, i_clk, i_rst_n, i_s_tvalid && o_s_tready, r_state == S_DECODE)
    `LZD_ASSERT_IMPL(a_partial_is_last, i_clk, i_rst_n, o_m_tvalid && !o_m_tlast, o_m_tdata[67:64] == LZD_CNT_W'(LZD_OUT_LANES))
    `LZD_ASSERT_IMPL(a_empty_has_status, i_clk, i_rst_n, o_m_tvalid && o_m_tdata[67:64] == '0, o_m_tlast && o_m_tuser != ST_DATA)
    `LZD_ASSERT_IMPL(a_idle_pack_clear, i_clk, i_rst_n, r_state == S_IDLE, r_cnt == '0 && !r_has_final)

endmodule

### rtl/lzd_window.sv
// History window RAM: one write port, one read port with registered data.
// Depends on lzd_pkg for the default depth.
module lzd_window
    import lzd_pkg::*;
#(
    parameter int ADDR_BITS = LZD_WINDOW_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [7:0]           i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [7:0]           o_rdata
);

    logic [7:0] r_mem [0:(1 << ADDR_BITS)-1];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sim/testbench.sv
// Self-checking testbench for lz77_token_decompressor: directed and random compressed
// streams are sent over the input stream, and every output transfer is checked against
// an in-bench decoder. Depends on lzd_pkg and the RTL top level.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import lzd_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = 600;

    typedef enum logic [3:0] {
        PARSE_MAGIC0, PARSE_MAGIC1, PARSE_SIZE0, PARSE_SIZE1, PARSE_SIZE2, PARSE_SIZE3,
        PARSE_TOKEN, PARSE_OFFLO, PARSE_LEN, PARSE_DONE, PARSE_ERROR
    } t_parse;

    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  count;
        logic        last;
        t_status     status;
    } t_pack;

    typedef logic [7:0] t_byte_q[$];

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [7:0]             i_s_tdata = '0;   // [7:0] in_byte
    logic                   i_s_tlast = 1'b0; // end_of_stream
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [LZD_TDATA_W-1:0] o_m_tdata;        // [63:0] out_bytes, [67:64] byte_count
    logic                   o_m_tlast;        // last_in_run
    logic [1:0]             o_m_tuser;        // [1:0] status

    lz77_token_decompressor dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // decoder state
    logic [7:0]  win_mem [1 << LZD_WINDOW_BITS];
    logic [11:0] wr_ptr;
    t_parse      parse;
    logic [31:0] out_size;
    logic [31:0] made_cnt;
    logic [14:0] copy_offset;
    logic [7:0]  run_bytes[$];

    t_pack expected_packs[$];
    int    live_items = 0;
    int    mismatches = 0;
    int    stall_cycles = 0;
    int    send_idle_pct = 0;
    int    recv_idle_pct = 0;

    function automatic void clear_decoder();
        foreach (win_mem[i]) win_mem[i] = 8'h00;
        wr_ptr      = '0;
        parse       = PARSE_MAGIC0;
        out_size    = '0;
        made_cnt    = '0;
        copy_offset = '0;
    endfunction

    function automatic void put_window_byte(input logic [7:0] b);
        win_mem[wr_ptr] = b;
        wr_ptr = wr_ptr + 12'd1;
        run_bytes.push_back(b);
        made_cnt = made_cnt + 32'd1;
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic eos);
        logic        has_fin;
        t_status     fin_st;
        logic [11:0] copy_dist;
        logic [11:0] rd_ptr;
        int          copy_len;
        int          packs;
        int          n;
        int          cnt;
        logic [63:0] word;
        t_pack       r;

        has_fin = 1'b0;
        fin_st  = ST_DATA;
        run_bytes.delete();
        live_items++;

        case (parse)
            PARSE_MAGIC0, PARSE_MAGIC1: begin
                if (b == ((parse == PARSE_MAGIC0) ? LZD_MAGIC0 : LZD_MAGIC1)) begin
                    parse = t_parse'(parse + 1);
                end else begin
                    has_fin = 1'b1;
                    fin_st  = ST_BADMAGIC;
                    parse   = PARSE_ERROR;
                end
            end
            PARSE_SIZE0, PARSE_SIZE1, PARSE_SIZE2, PARSE_SIZE3: begin
                out_size = out_size | (32'(b) << (8 * (int'(parse) - int'(PARSE_SIZE0))));
                parse = t_parse'(parse + 1);
                if (parse == PARSE_TOKEN && out_size == 0) begin
                    has_fin = 1'b1;
                    fin_st  = ST_FINISHED;
                    parse   = PARSE_DONE;
                end
            end
            PARSE_TOKEN: begin
                if (b[7]) begin
                    copy_offset = {8'h00, b[6:0]};
                    parse = PARSE_OFFLO;
                end else begin
                    put_window_byte(b);
                end
            end
            PARSE_OFFLO: begin
                copy_offset = {copy_offset[6:0], b};
                parse = PARSE_LEN;
            end
            PARSE_LEN: begin
                if (copy_offset == 0) begin
                    has_fin = 1'b1;
                    fin_st  = ST_FINISHED;
                    parse   = PARSE_DONE;
                end else begin
                    copy_dist = copy_offset[11:0];
                    copy_len = int'(b) + LZD_MIN_COPY;
                    for (int i = 0; i < copy_len && made_cnt < out_size; i++) begin
                        rd_ptr = wr_ptr - copy_dist;
                        put_window_byte(win_mem[rd_ptr]);
                    end
                    parse = PARSE_TOKEN;
                end
            end
            default: ;
        endcase

        if (parse == PARSE_TOKEN && made_cnt >= out_size) begin
            has_fin = 1'b1;
            fin_st  = ST_FINISHED;
            parse   = PARSE_DONE;
        end

        if (eos && !has_fin) begin
            if (parse == PARSE_TOKEN) begin
                has_fin = 1'b1;
                fin_st  = ST_FINISHED;
            end else if (parse < PARSE_DONE) begin
                has_fin = 1'b1;
                fin_st  = ST_TRUNC;
            end
        end

        n = run_bytes.size();
        packs = (n + LZD_OUT_LANES - 1) / LZD_OUT_LANES;
        if (packs == 0 && has_fin) packs = 1;
        for (int k = 0; k < packs; k++) begin
            word = '0;
            cnt = 0;
            for (int j = 0; j < LZD_OUT_LANES; j++) begin
                if (k * LZD_OUT_LANES + j < n) begin
                    word[8*j +: 8] = run_bytes[k * LZD_OUT_LANES + j];
                    cnt++;
                end
            end
            r.data   = word;
            r.count  = cnt[3:0];
            r.last   = (k == packs - 1);
            r.status = (k == packs - 1 && has_fin) ? fin_st : ST_DATA;
            expected_packs.push_back(r);
        end

        if (eos) clear_decoder();
    endfunction

    // output side
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic report_mismatch(input string field, input logic [63:0] want,
                                   input logic [63:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %h got %h", field, want, got);
    endtask

    always @(posedge i_clk) begin
        t_pack e;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_packs.size() == 0) begin
                report_mismatch("unexpected transfer", 64'd0, o_m_tdata[63:0]);
            end else begin
                e = expected_packs.pop_front();
                if (o_m_tdata[63:0] !== e.data)
                    report_mismatch("out_bytes", e.data, o_m_tdata[63:0]);
                if (o_m_tdata[67:64] !== e.count)
                    report_mismatch("byte_count", 64'(e.count), 64'(o_m_tdata[67:64]));
                if (o_m_tlast !== e.last)
                    report_mismatch("last_in_run", 64'(e.last), 64'(o_m_tlast));
                if (o_m_tuser !== e.status)
                    report_mismatch("status", 64'(e.status), 64'(o_m_tuser));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL lz77_token_decompressor");
            $finish;
        end
    end

    // input side; entered and left at a rising edge, valid left high after a transfer
    task automatic send_byte(input logic [7:0] b, input logic eos);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= eos;
        do @(posedge i_clk); while (!o_s_tready);
        decode_byte(b, eos);
    endtask

    task automatic send_stream(input t_byte_q s);
        foreach (s[i]) send_byte(s[i], i == s.size() - 1);
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_packs.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_byte_q make_stream();
        t_byte_q     s;
        int          r;
        int          ntok;
        logic [31:0] size;
        logic [14:0] off;
        logic [7:0]  len;

        r = $urandom_range(99);
        if (r < 15) begin
            ntok = $urandom_range(1, 6);
            for (int i = 0; i < ntok; i++) s.push_back(8'($urandom_range(255)));
            if ($urandom_range(1)) s[0] = LZD_MAGIC0;
            return s;
        end
        s.push_back(LZD_MAGIC0);
        s.push_back(LZD_MAGIC1);
        r = $urandom_range(99);
        if (r < 60)      size = $urandom_range(1, 48);
        else if (r < 85) size = $urandom_range(64, 600);
        else if (r < 92) size = $urandom;
        else if (r < 96) size = '0;
        else             size = 32'hFFFF_FFFF;
        for (int i = 0; i < 4; i++) s.push_back(size[8*i +: 8]);

        ntok = $urandom_range(1, 12);
        for (int t = 0; t < ntok; t++) begin
            if ($urandom_range(99) < 60) begin
                s.push_back(8'($urandom_range(0, 127)));
            end else begin
                r = $urandom_range(99);
                if (r < 60)      off = 15'($urandom_range(1, 16));
                else if (r < 80) off = 15'($urandom_range(17, 4095));
                else if (r < 90) off = 15'($urandom);
                else if (r < 95) off = 15'($urandom_range(1, 7) << LZD_WINDOW_BITS);
                else             off = '0;
                r = $urandom_range(99);
                if (r < 80)      len = 8'($urandom_range(0, 13));
                else if (r < 95) len = 8'($urandom_range(14, 60));
                else             len = 8'($urandom_range(200, 255));
                s.push_back({1'b1, off[14:8]});
                s.push_back(off[7:0]);
                s.push_back(len);
            end
        end

        r = $urandom_range(99);
        if (r < 15) begin
            ntok = $urandom_range(1, s.size());
            while (s.size() > ntok) void'(s.pop_back());
        end else if (r < 28) begin
            s.push_back(8'($urandom_range(255)));
        end
        return s;
    endfunction

    task automatic test_header_errors();
        send_stream('{8'hFF});
        send_stream('{LZD_MAGIC0, 8'h00, 8'h33});
        send_stream('{LZD_MAGIC0, LZD_MAGIC1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h12});
        send_stream('{LZD_MAGIC0, LZD_MAGIC1, 8'h07});
    endtask

    task automatic test_token_cases();
        // literals, overlapping copy, offset that wraps the window, copy cut at size
        send_stream('{LZD_MAGIC0, LZD_MAGIC1, 8'h0C, 8'h00, 8'h00, 8'h00,
                      8'h00, 8'h7F, 8'h80, 8'h01, 8'h00, 8'hF0, 8'h00, 8'h00,
                      8'h80, 8'h02, 8'hFF});
        // end marker
        send_stream('{LZD_MAGIC0, LZD_MAGIC1, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                      8'h41, 8'h80, 8'h00, 8'h09});
        // stream end between tokens, then inside a match
        send_stream('{LZD_MAGIC0, LZD_MAGIC1, 8'h20, 8'h00, 8'h00, 8'h00, 8'h41});
        send_stream('{LZD_MAGIC0, LZD_MAGIC1, 8'h03, 8'h00, 8'h00, 8'h00, 8'h81});
    endtask

    task automatic test_random_streams(input int n_items);
        int start;
        start = live_items;
        while (live_items - start < n_items) send_stream(make_stream());
    endtask

    initial begin
        clear_decoder();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        send_idle_pct = 35;
        recv_idle_pct = 87;
        test_header_errors();
        test_token_cases();
        test_random_streams(160);
        wait_drained();

        send_idle_pct = 87;
        recv_idle_pct = 35;
        test_random_streams(160);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_streams(160);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && expected_packs.size() == 0) begin
            $display("PASS lz77_token_decompressor");
        end else begin
            $display("FAIL lz77_token_decompressor");
        end
        $finish;
    end
endmodule
